FILE: src/register_bytecode_executor_assert.svh
// assertion macros for the register bytecode executor
// expects signals clk and arst_n in the including module
`ifndef REGISTER_BYTECODE_EXECUTOR_ASSERT_SVH
`define REGISTER_BYTECODE_EXECUTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rbe_pkg.sv
// shared types, constants and saturation helpers for the bytecode executor
// no dependencies
package rbe_pkg;

	localparam int REGISTER_COUNT_DEF = 256;
	localparam int FRACTION_BITS_DEF  = 32;

	localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		OP_HALT, OP_LDC, OP_NEG, OP_MOD, OP_MUL, OP_ADD, OP_SUB, OP_DIV
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_A, ST_RD_B, ST_EXEC, ST_MUL, ST_MSAT, ST_DIV, ST_DFIN, ST_WB, ST_HALT
	} state_t;

	typedef struct packed {
		logic [63:0] val;
		logic        ovf;
	} sat_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	// apply sign to a magnitude, saturating; big marks a magnitude past 64 bits
	function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag, input logic big);
		sat_t r;
		if (neg) begin
			if (big || mag > SIGN_MIN) begin
				r.val = SIGN_MIN;
				r.ovf = 1'b1;
			end else begin
				r.val = 64'd0 - mag;
				r.ovf = 1'b0;
			end
		end else begin
			if (big || mag > POS_MAX) begin
				r.val = POS_MAX;
				r.ovf = 1'b1;
			end else begin
				r.val = mag;
				r.ovf = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

FILE: src/register_bytecode_executor.sv
// register bytecode executor: sequencer, register file memory and arithmetic units
// depends on rbe_pkg and register_bytecode_executor_assert.svh

// Executes one bytecode instruction per input item against a register file of
// signed fixed-point values (FRACTION_BITS fraction bits, 64 bits total) held
// in a single synchronous memory. Items are taken one at a time; a halt waits
// until the previous report has been taken. Multiply runs four 32x32 partial
// products through one multiplier; divide and modulo make one quotient bit
// per cycle in a shared restoring divider, which a zero divisor skips. The
// two operand reads share the memory's one read port. Only a halt gives a
// result item; it carries the chosen register and the sticky overflow and
// zero-divisor flags, which it then clears. A report waiting on the output
// register does not stop the next item from being accepted. Registers at or
// beyond REGISTER_COUNT read as zero and ignore writes; reading a register
// never written since reset returns whatever the memory holds.
module register_bytecode_executor #(
	parameter int REGISTER_COUNT = rbe_pkg::REGISTER_COUNT_DEF,
	parameter int FRACTION_BITS  = rbe_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[2:0], dest_register[10:3], first_source[18:11],
	// second_source[26:19], constant_value[90:27], zero fill above
	input  logic [95:0] s_axis_tdata,
	// item out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_value[63:0], overflow_seen[64], zero_divisor_seen[65], zero fill above
	output logic [71:0] m_axis_tdata
);
	import rbe_pkg::*;

	localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
	localparam int CW = $clog2(64 + FRACTION_BITS + 1);

	// control state
	state_t state_q, state_n;
	logic [CW-1:0] cnt_q;
	logic ovf_q, zdv_q;
	logic out_valid_q;

	// latched instruction
	op_t op_q;
	logic [7:0] dst_q, src1_q, src2_q;
	logic [63:0] const_q;

	// register file
	logic [63:0] mem [REGISTER_COUNT];
	logic [63:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic wr_en;

	// datapath registers
	logic [63:0] a_q, res_q;
	logic [63:0] x_q, y_q;
	logic neg_q;
	logic [63:0] pp_q;
	logic [1:0] pp_sel_q;
	logic [127:0] prod_q;
	logic [127:0] shr_q;
	logic [63:0] d_q, rem_q, quo_q;
	logic big_q, is_mod_q;
	logic [63:0] out_val_q;
	logic out_ovf_q, out_zdv_q;

	logic accept, out_free;
	logic [63:0] b_val, a_val;
	logic [63:0] ex_res;
	logic ex_ovf, ex_zdv;
	logic [63:0] fin_res;
	logic fin_ovf;
	logic [31:0] mul_a, mul_b;
	logic [63:0] pp_n;
	logic [64:0] rem_sh, rem_sub;
	logic rem_ge;
	logic [63:0] mag_a, mag_b, int_b, add_s, sub_d, mod_r;
	logic [127:0] prod_sh;
	sat_t sat_r;

	function automatic logic in_range(input logic [7:0] idx);
		in_range = ({1'b0, idx} < 9'(REGISTER_COUNT));
	endfunction

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_zdv_q, out_ovf_q, out_val_q};

	// operand values, out-of-range registers read as zero
	assign a_val = in_range((op_q == OP_HALT) ? dst_q : src1_q) ? rd_data_q : 64'd0;
	assign b_val = in_range(src2_q) ? rd_data_q : 64'd0;

	// sequencer
	always_comb begin
		state_n       = state_q;
		s_axis_tready = 1'b0;
		wr_en         = 1'b0;
		if (state_q == ST_RD_B && op_q != OP_HALT) begin
			rd_addr = src2_q[AW-1:0];
		end else if (op_q == OP_HALT) begin
			rd_addr = dst_q[AW-1:0];
		end else begin
			rd_addr = src1_q[AW-1:0];
		end
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_n = ST_RD_A;
			end
			ST_RD_A: state_n = ST_RD_B;
			ST_RD_B: state_n = (op_q == OP_HALT) ? ST_HALT : ST_EXEC;
			ST_EXEC: begin
				if (op_q == OP_MUL) begin
					state_n = ST_MUL;
				end else if ((op_q == OP_DIV || op_q == OP_MOD) && !ex_zdv) begin
					state_n = ST_DIV;
				end else begin
					state_n = ST_WB;
				end
			end
			ST_MUL:  if (cnt_q == CW'(4)) state_n = ST_MSAT;
			ST_MSAT: state_n = ST_WB;
			ST_DIV:  if (cnt_q == CW'(1)) state_n = ST_DFIN;
			ST_DFIN: state_n = ST_WB;
			ST_WB: begin
				wr_en   = in_range(dst_q);
				state_n = ST_IDLE;
			end
			ST_HALT: if (out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// operations finished in the execute state, and setup checks for the long ones
	always_comb begin
		mag_a  = mag64(a_q);
		mag_b  = mag64(b_val);
		int_b  = mag_b >> FRACTION_BITS;
		add_s  = a_q + b_val;
		sub_d  = a_q - b_val;
		ex_res = 64'd0;
		ex_ovf = 1'b0;
		ex_zdv = 1'b0;
		case (op_q)
			OP_LDC: ex_res = const_q;
			OP_NEG: begin
				if (a_q == SIGN_MIN) begin
					ex_res = POS_MAX;
					ex_ovf = 1'b1;
				end else begin
					ex_res = 64'd0 - a_q;
				end
			end
			OP_ADD: begin
				ex_ovf = (a_q[63] ^ add_s[63]) & (b_val[63] ^ add_s[63]);
				ex_res = ex_ovf ? (a_q[63] ? SIGN_MIN : POS_MAX) : add_s;
			end
			OP_SUB: begin
				ex_ovf = (a_q[63] ^ b_val[63]) & (a_q[63] ^ sub_d[63]);
				ex_res = ex_ovf ? (a_q[63] ? SIGN_MIN : POS_MAX) : sub_d;
			end
			OP_DIV: begin
				// zero divisor saturates by the dividend's sign, 0/0 gives 0
				ex_zdv = (b_val == 64'd0);
				if (a_q == 64'd0) ex_res = 64'd0;
				else ex_res = a_q[63] ? SIGN_MIN : POS_MAX;
			end
			OP_MOD: ex_zdv = (int_b == 64'd0);
			default: ex_res = 64'd0;
		endcase
	end

	// partial product select and one multiplier
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    begin mul_a = x_q[31:0];  mul_b = y_q[31:0];  end
			2'd1:    begin mul_a = x_q[31:0];  mul_b = y_q[63:32]; end
			2'd2:    begin mul_a = x_q[63:32]; mul_b = y_q[31:0];  end
			default: begin mul_a = x_q[63:32]; mul_b = y_q[63:32]; end
		endcase
	end
	assign pp_n = {32'd0, mul_a} * {32'd0, mul_b};

	// one restoring divider step
	assign rem_sh  = {rem_q, shr_q[127]};
	assign rem_ge  = (rem_sh >= {1'b0, d_q});
	assign rem_sub = rem_sh - {1'b0, d_q};

	// final saturation of product or quotient, and the signed remainder
	always_comb begin
		prod_sh = prod_q >> FRACTION_BITS;
		mod_r   = rem_q << FRACTION_BITS;
		if (state_q == ST_MSAT) begin
			sat_r = sat_mag(neg_q, prod_sh[63:0], |prod_sh[127:64]);
		end else begin
			sat_r = sat_mag(neg_q, quo_q, big_q);
		end
		if (state_q == ST_DFIN && is_mod_q) begin
			fin_res = neg_q ? (64'd0 - mod_r) : mod_r;
			fin_ovf = 1'b0;
		end else begin
			fin_res = sat_r.val;
			fin_ovf = sat_r.ovf;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			zdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_HALT && out_free) begin
				out_valid_q <= 1'b1;
				ovf_q       <= 1'b0;
				zdv_q       <= 1'b0;
			end else begin
				if (m_axis_tready) out_valid_q <= 1'b0;
				if (state_q == ST_EXEC) begin
					ovf_q <= ovf_q | ex_ovf;
					zdv_q <= zdv_q | ex_zdv;
				end
				if (state_q == ST_MSAT || state_q == ST_DFIN) ovf_q <= ovf_q | fin_ovf;
			end
			case (state_q)
				ST_EXEC: begin
					if (op_q == OP_DIV) cnt_q <= CW'(64 + FRACTION_BITS);
					else if (op_q == OP_MOD) cnt_q <= CW'(64 - FRACTION_BITS);
					else cnt_q <= '0;
				end
				ST_MUL:  cnt_q <= cnt_q + CW'(1);
				ST_DIV:  cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// register file, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) mem[dst_q[AW-1:0]] <= res_q;
		rd_data_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(s_axis_tdata[2:0]);
			dst_q   <= s_axis_tdata[10:3];
			src1_q  <= s_axis_tdata[18:11];
			src2_q  <= s_axis_tdata[26:19];
			const_q <= s_axis_tdata[90:27];
		end
		if (state_q == ST_RD_B) a_q <= a_val;
		case (state_q)
			ST_EXEC: begin
				res_q    <= ex_res;
				x_q      <= mag_a;
				y_q      <= mag_b;
				prod_q   <= '0;
				rem_q    <= '0;
				quo_q    <= '0;
				big_q    <= 1'b0;
				is_mod_q <= (op_q == OP_MOD);
				if (op_q == OP_MOD) begin
					neg_q <= a_q[63];
					shr_q <= {(mag_a >> FRACTION_BITS) << FRACTION_BITS, 64'd0};
					d_q   <= int_b;
				end else begin
					neg_q <= a_q[63] ^ b_val[63];
					shr_q <= {mag_a, 64'd0};
					d_q   <= mag_b;
				end
			end
			ST_MUL: begin
				pp_q <= pp_n;
				case (cnt_q[1:0])
					2'd0:    pp_sel_q <= 2'd0;
					2'd3:    pp_sel_q <= 2'd2;
					default: pp_sel_q <= 2'd1;
				endcase
				if (cnt_q != '0) prod_q <= prod_q + ({64'd0, pp_q} << (32 * pp_sel_q));
			end
			ST_DIV: begin
				shr_q <= shr_q << 1;
				rem_q <= rem_ge ? rem_sub[63:0] : rem_sh[63:0];
				if (quo_q[63]) big_q <= 1'b1;
				quo_q <= {quo_q[62:0], rem_ge};
			end
			ST_MSAT, ST_DFIN: res_q <= fin_res;
			ST_HALT: begin
				if (out_free) begin
					out_val_q <= a_q;
					out_ovf_q <= ovf_q;
					out_zdv_q <= zdv_q;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	`include "register_bytecode_executor_assert.svh"

	`RBE_ASSERT_NEXT(a_accept_reads, accept, state_q == ST_RD_A, "accepted item did not start a read")
	`RBE_ASSERT_NEXT(a_halt_clears, state_q == ST_HALT && out_free, !ovf_q && !zdv_q && out_valid_q, "halt report did not clear flags")
	`RBE_ASSERT_NOW(a_div_count, state_q == ST_DIV, cnt_q != '0, "divider running with zero count")
	`RBE_ASSERT_NOW(a_write_state, wr_en, state_q == ST_WB, "register write outside writeback")

endmodule

FILE: sim/tb.sv
// testbench for register_bytecode_executor: random and directed bytecode with a fixed-point predictor
// depends on rbe_pkg and the register_bytecode_executor rtl
`timescale 1ns / 100ps

module tb;
	import rbe_pkg::*;

	localparam int REGS = 256;
	localparam int FRAC = 32;
	localparam int NUM_ITEMS = 1500;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [63:0] val;
		logic        ovf;
		logic        zdiv;
	} report_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	register_bytecode_executor uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// predictor state
	logic [63:0] shadow_regs [REGS];
	bit          pend_ovf, pend_zdiv;

	logic [95:0] pending_items[$];
	report_t     expected_reports[$];
	int          fail_count;
	int          reports_seen;
	int          ops_seen [8];
	bit          calm;        // no random idling on either side
	bit          hold_off;    // receiver parked for a long stretch
	int          idle_cycles;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// saturate a magnitude with sign; big means past 64 bits
	function automatic logic [63:0] fx_sat(bit neg, logic [63:0] mag, bit big);
		if (neg) begin
			if (big || mag > SIGN_MIN) begin pend_ovf = 1; return SIGN_MIN; end
			return 64'd0 - mag;
		end
		if (big || mag > POS_MAX) begin pend_ovf = 1; return POS_MAX; end
		return mag;
	endfunction

	function automatic logic [63:0] fx_abs(logic [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	function automatic logic [63:0] rd(logic [7:0] idx);
		return (idx < REGS) ? shadow_regs[idx] : 64'd0;
	endfunction

	// executes one instruction on the shadow state; returns 1 when a report results
	function automatic bit execute_instr(logic [95:0] d, output report_t rep);
		op_t         op;
		logic [7:0]  dst;
		logic [63:0] a, b, r, x, y;
		logic [127:0] prod, num, quo;
		bit          neg, wr;
		op  = op_t'(d[2:0]);
		dst = d[10:3];
		a   = rd(d[18:11]);
		b   = rd(d[26:19]);
		wr  = 1;
		r   = '0;
		neg = a[63] ^ b[63];
		case (op)
			OP_HALT: begin
				rep.val  = rd(dst);
				rep.ovf  = pend_ovf;
				rep.zdiv = pend_zdiv;
				pend_ovf = 0;
				pend_zdiv = 0;
				return 1;
			end
			OP_LDC: r = d[90:27];
			OP_NEG: begin
				if (a == SIGN_MIN) begin pend_ovf = 1; r = POS_MAX; end
				else r = 64'd0 - a;
			end
			OP_ADD, OP_SUB: begin
				y = (op == OP_ADD) ? b : 64'd0 - b;
				r = a + y;
				if ((op == OP_ADD && a[63] == b[63] && r[63] != a[63]) ||
				    (op == OP_SUB && a[63] != b[63] && r[63] != a[63])) begin
					pend_ovf = 1;
					r = a[63] ? SIGN_MIN : POS_MAX;
				end
			end
			OP_MUL: begin
				prod = {64'd0, fx_abs(a)} * {64'd0, fx_abs(b)};
				prod = prod >> FRAC;
				r = fx_sat(neg, prod[63:0], prod[127:64] != 0);
			end
			OP_DIV: begin
				if (b == 0) begin
					pend_zdiv = 1;
					r = (a == 0) ? 64'd0 : (a[63] ? SIGN_MIN : POS_MAX);
				end else begin
					num = {64'd0, fx_abs(a)} << FRAC;
					quo = num / {64'd0, fx_abs(b)};
					r = fx_sat(neg, quo[63:0], quo[127:64] != 0);
				end
			end
			OP_MOD: begin
				x = fx_abs(a) >> FRAC;
				y = fx_abs(b) >> FRAC;
				if (y == 0) begin pend_zdiv = 1; r = 0; end
				else begin
					r = (x % y) << FRAC;
					if (a[63]) r = 64'd0 - r;
				end
			end
			default: r = '0;
		endcase
		if (wr && dst < REGS) shadow_regs[dst] = r;
		return 0;
	endfunction

	function automatic logic [95:0] pack_instr(op_t op, logic [7:0] dst, logic [7:0] sa,
		logic [7:0] sb, logic [63:0] k);
		return {5'd0, k, sb, sa, dst, op};
	endfunction

	// queue-time view of which registers hold values, so sources are always written
	bit     live [REGS];
	byte    live_list[$];

	function automatic logic [7:0] pick_live();
		return live_list[$urandom_range(live_list.size() - 1)];
	endfunction

	function automatic void enqueue(logic [95:0] d);
		pending_items.push_back(d);
		if (d[2:0] != OP_HALT && !live[d[10:3]]) begin
			live[d[10:3]] = 1;
			live_list.push_back(d[10:3]);
		end
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(7))
			0: return SIGN_MIN;
			1: return POS_MAX;
			2: return 64'd0;
			3: return {$urandom, $urandom};
			4: return {{32{1'($urandom_range(1))}}, $urandom} << $urandom_range(32);
			5: return {32'(int'($urandom_range(40)) - 20), $urandom};
			6: return {32'(int'($urandom_range(6)) - 3), 32'd0};
			default: return {$urandom, $urandom} >> $urandom_range(63);
		endcase
	endfunction

	// stimulus
	initial begin
		op_t op;
		logic [7:0] dst;
		arst_n = 1'b0;
		calm = 0;
		hold_off = 0;
		// directed: extremes, every operation, zero divisors, saturation
		enqueue(pack_instr(OP_LDC, 8'd0, 8'hFF, 8'hFF, SIGN_MIN));
		enqueue(pack_instr(OP_LDC, 8'd1, 8'd0, 8'd0, POS_MAX));
		enqueue(pack_instr(OP_LDC, 8'd2, 8'd0, 8'd0, 64'd0));
		enqueue(pack_instr(OP_LDC, 8'd255, 8'd0, 8'd0, 64'h0000_0000_8000_0000));
		enqueue(pack_instr(OP_LDC, 8'd3, 8'd0, 8'd0, 64'hFFFF_FFF9_4000_0000));
		enqueue(pack_instr(OP_LDC, 8'd4, 8'd0, 8'd0, 64'h0000_0002_0000_0000));
		enqueue(pack_instr(OP_NEG, 8'd5, 8'd0, 8'd0, '1));
		enqueue(pack_instr(OP_HALT, 8'd5, 8'd0, 8'd0, '0));
		enqueue(pack_instr(OP_ADD, 8'd6, 8'd1, 8'd1, '0));
		enqueue(pack_instr(OP_SUB, 8'd7, 8'd0, 8'd1, '0));
		enqueue(pack_instr(OP_MUL, 8'd8, 8'd1, 8'd1, '0));
		enqueue(pack_instr(OP_MUL, 8'd9, 8'd3, 8'd4, '0));
		enqueue(pack_instr(OP_HALT, 8'd9, 8'd0, 8'd0, '0));
		enqueue(pack_instr(OP_DIV, 8'd10, 8'd1, 8'd2, '0));
		enqueue(pack_instr(OP_DIV, 8'd11, 8'd0, 8'd2, '0));
		enqueue(pack_instr(OP_DIV, 8'd12, 8'd2, 8'd2, '0));
		enqueue(pack_instr(OP_HALT, 8'd11, 8'd0, 8'd0, '0));
		enqueue(pack_instr(OP_MOD, 8'd13, 8'd3, 8'd4, '0));
		enqueue(pack_instr(OP_MOD, 8'd14, 8'd3, 8'd255, '0)); // divisor below one
		enqueue(pack_instr(OP_DIV, 8'd15, 8'd1, 8'd255, '0)); // quotient overflow
		enqueue(pack_instr(OP_HALT, 8'd13, 8'd0, 8'd0, '0));
		enqueue(pack_instr(OP_HALT, 8'd255, 8'd0, 8'd0, '0));
		// random part: valid sources, halts often enough for many reports
		for (int i = 0; i < NUM_ITEMS; i++) begin
			op  = op_t'($urandom_range(7));
			dst = ($urandom_range(3) == 0) ? pick_live() : 8'($urandom);
			if ($urandom_range(4) == 0) op = OP_HALT;
			if (live_list.size() < 4 || $urandom_range(5) == 0) op = OP_LDC;
			if (op == OP_HALT) dst = pick_live();
			enqueue(pack_instr(op, dst, pick_live(), pick_live(),
				(op == OP_LDC) ? rand_value() : {$urandom, $urandom}));
		end
		enqueue(pack_instr(OP_HALT, pick_live(), 8'd0, 8'd0, '0));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// long calm stretch, then a long receiver hold-off, each once
	initial begin
		wait (arst_n);
		wait (reports_seen >= 30);
		calm = 1;
		wait (reports_seen >= 120);
		calm = 0;
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				report_t rep;
				ops_seen[s_axis_tdata[2:0]]++;
				if (execute_instr(s_axis_tdata, rep))
					expected_reports.push_back(rep);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_items.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				report_t got, want;
				got.val  = m_axis_tdata[63:0];
				got.ovf  = m_axis_tdata[64];
				got.zdiv = m_axis_tdata[65];
				reports_seen++;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (got.val !== want.val) begin
						$display("%0t: value expected %h actual %h", $time, want.val, got.val);
						fail_count++;
					end
					if (got.ovf !== want.ovf) begin
						$display("%0t: overflow flag expected %b actual %b", $time,
							want.ovf, got.ovf);
						fail_count++;
					end
					if (got.zdiv !== want.zdiv) begin
						$display("%0t: zero divisor flag expected %b actual %b", $time,
							want.zdiv, got.zdiv);
						fail_count++;
					end
				end
			end
			m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 31);
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (pending_items.size() == 0 && !s_axis_tvalid);
				wait (expected_reports.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
				$display("ran %0d instructions (halt %0d, ldc %0d, neg %0d, mod %0d,",
					NUM_ITEMS + 23, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
				$display("  mul %0d, add %0d, sub %0d, div %0d), checked %0d reports",
					ops_seen[4], ops_seen[5], ops_seen[6], ops_seen[7], reports_seen);
				if (fail_count == 0)
					$display("register_bytecode_executor: match");
				else
					$display("register_bytecode_executor: mismatch");
				$finish;
			end
			begin
				wait (idle_cycles >= WATCHDOG_LIMIT);
				$display("%0t: watchdog expired", $time);
				$display("register_bytecode_executor: mismatch");
				$finish;
			end
		join
	end

endmodule
